### sv/dfsa_pkg.sv
// Shared types, widths and codes for the deferred-free slot allocator.
// Used by the divider, the RAM wrapper users and the top level; no dependencies.
`default_nettype none

package dfsa_pkg;

  localparam int MAX_SLOTS     = 4096;
  localparam int SAMPLER_LIMIT = 2048;
  localparam int FRAMES        = 4;

  localparam int SLOT_W   = $clog2(MAX_SLOTS);
  localparam int CNT_W    = SLOT_W + 1;
  localparam int FRAME_W  = 2;
  localparam int OFF_W    = 20;
  localparam int CAP_W    = 13;
  localparam int DSZ_W    = 9;
  localparam int HTYPE_W  = 2;
  localparam int STATUS_W = 3;
  localparam int DEFER_AW = FRAME_W + SLOT_W;
  localparam int DIV_CNT_W = $clog2(OFF_W);
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  localparam logic [DSZ_W-1:0] DSZ_RESET = DSZ_W'(32);

  typedef enum logic [1:0] {
    MODE_INIT    = 2'd0,
    MODE_ALLOC   = 2'd1,
    MODE_FREE    = 2'd2,
    MODE_PROCESS = 2'd3
  } mode_e;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BIG     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd5;

  localparam logic [HTYPE_W-1:0] HEAP_SAMPLER = 2'd1;
  localparam logic [HTYPE_W-1:0] HEAP_RTV     = 2'd2;

  localparam logic [1:0] REG_CAPACITY = 2'd0;
  localparam logic [1:0] REG_DSZ      = 2'd1;
  localparam logic [1:0] REG_HTYPE    = 2'd2;
  localparam logic [1:0] REG_VISIBLE  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_ALLOC,
    S_DIV,
    S_PROC_RD,
    S_PROC_WR
  } state_e;

  typedef struct packed {
    logic             start;
    logic [OFF_W-1:0] dividend;
    logic [DSZ_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [OFF_W-1:0] quot;
    logic [DSZ_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

### sv/dfsa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module dfsa_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 12
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### sv/dfsa_div.sv
// Restoring divider, one quotient bit per cycle, for byte offset to slot index.
// Depends on dfsa_pkg.
`default_nettype none

module dfsa_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dfsa_pkg::div_req_t req_i,
  output dfsa_pkg::div_rsp_t      rsp_o
);

  import dfsa_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [OFF_W-1:0]     quot_q, quot_d;
  logic [DSZ_W-1:0]     rem_q, rem_d;
  logic [DSZ_W-1:0]     dsr_q, dsr_d;
  logic [DSZ_W:0]       trial;
  logic                 fits;

  assign trial = {rem_q, quot_q[OFF_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      // The trial value stays below twice the divisor, so the difference fits.
      rem_d  = fits ? DSZ_W'(trial - {1'b0, dsr_q}) : trial[DSZ_W-1:0];
      quot_d = {quot_q[OFF_W-2:0], fits};
      cnt_d  = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(OFF_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

### sv/deferred_free_slot_allocator.sv
// Deferred-free slot allocator: free-index stack plus one deferred-free list per frame.
// Allocate reads the stack top, then answers; free runs the serial divider; init fills the
// stack, one entry per cycle; process walks the deferred list (read, then push back).
// One item at a time; busy is high while an item is at work; results cannot be stalled.
// Reset: heap not ready, no slots in use, all deferred lists empty, descriptor size 32.
// Depends on dfsa_pkg, dfsa_ram and dfsa_div.
`default_nettype none

module deferred_free_slot_allocator (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration port.
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [dfsa_pkg::CFG_AW-1:0]    paddr,
  input  wire logic [dfsa_pkg::CFG_DW-1:0]    pwdata,
  output logic      [dfsa_pkg::CFG_DW-1:0]    prdata,
  output logic                                pready,
  // Command side.
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     mode_i,
  input  wire logic                           handle_valid_i,
  input  wire logic [dfsa_pkg::OFF_W-1:0]     handle_offset_i,
  input  wire logic [dfsa_pkg::FRAME_W-1:0]   frame_i,
  // Result side.
  output logic                                done_o,
  output logic      [dfsa_pkg::STATUS_W-1:0]  status_o,
  output logic      [dfsa_pkg::SLOT_W-1:0]    slot_index_o,
  output logic      [dfsa_pkg::OFF_W-1:0]     slot_offset_o,
  output logic                                gpu_valid_o,
  output logic      [dfsa_pkg::CNT_W-1:0]     in_use_o
);

  import dfsa_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes complete on the access beat; reads are
  // combinational and pready is tied high.
  // ---------------------------------------------------------------------------
  logic [CAP_W-1:0]   cap_cfg_q;
  logic [DSZ_W-1:0]   ds_q;
  logic [HTYPE_W-1:0] htype_q;
  logic               vreq_q;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_cfg_q <= '0;
      ds_q      <= DSZ_RESET;
      htype_q   <= '0;
      vreq_q    <= 1'b0;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_CAPACITY: cap_cfg_q <= pwdata[CAP_W-1:0];
        REG_DSZ:      ds_q      <= pwdata[DSZ_W-1:0];
        REG_HTYPE:    htype_q   <= pwdata[HTYPE_W-1:0];
        REG_VISIBLE:  vreq_q    <= pwdata[0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CAPACITY: prdata = CFG_DW'(cap_cfg_q);
      REG_DSZ:      prdata = CFG_DW'(ds_q);
      REG_HTYPE:    prdata = CFG_DW'(htype_q);
      REG_VISIBLE:  prdata = CFG_DW'(vreq_q);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Allocator state. The free stack and the deferred lists live in RAM; the
  // small per-frame counters, the used count and the heap flags are flops.
  // ---------------------------------------------------------------------------
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   used_q, used_d;
  logic [CAP_W-1:0]   cap_lat_q, cap_lat_d;
  logic               ready_q, ready_d;
  logic               vis_q, vis_d;
  logic [CNT_W-1:0]   cnt_q [FRAMES];
  logic [CNT_W-1:0]   cnt_d [FRAMES];
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [CNT_W-1:0]   pidx_q, pidx_d;
  logic [FRAME_W-1:0] frame_q;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // Frame of the current item is taken at the accept beat for the multi-cycle modes.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      frame_q <= frame_i;
    end
  end

  // RAM ports.
  logic              stk_we, stk_re;
  logic [SLOT_W-1:0] stk_waddr, stk_wdata, stk_raddr, stk_rdata;
  logic                dfr_we, dfr_re;
  logic [DEFER_AW-1:0] dfr_waddr, dfr_raddr;
  logic [SLOT_W-1:0]   dfr_wdata, dfr_rdata;

  dfsa_ram #(.ADDR_W(SLOT_W), .DATA_W(SLOT_W)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  dfsa_ram #(.ADDR_W(DEFER_AW), .DATA_W(SLOT_W)) u_defer_ram (
    .clk_i   (clk_i),
    .we_i    (dfr_we),
    .waddr_i (dfr_waddr),
    .wdata_i (dfr_wdata),
    .re_i    (dfr_re),
    .raddr_i (dfr_raddr),
    .rdata_o (dfr_rdata)
  );

  // Offset to index conversion runs on the serial divider.
  div_req_t div_req;
  div_rsp_t div_rsp;

  dfsa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // Shared decision terms, used by both the next-state and the output logic.
  // ---------------------------------------------------------------------------
  mode_e                      mode;
  logic                       cap_big, alloc_full, frame_oob;
  logic                       free_early, proc_early;
  logic [CNT_W-1:0]           fill_inc, used_dec, pidx_inc;
  logic                       fill_last, proc_last;
  logic                       div_bad, defer_full;
  logic [SLOT_W+DSZ_W-1:0]    mul;

  assign mode      = mode_e'(mode_i);
  assign cap_big   = (32'(cap_cfg_q) > MAX_SLOTS) ||
                     ((htype_q == HEAP_SAMPLER) && (32'(cap_cfg_q) > SAMPLER_LIMIT));
  assign alloc_full = !ready_q || (32'(used_q) >= 32'(cap_lat_q));
  assign frame_oob = 32'(frame_i) >= FRAMES;

  // A free that never reaches the divider: empty handle, frame out of range, empty heap, or a zero stride.
  assign free_early = !handle_valid_i || frame_oob || (ready_q && (used_q == '0)) ||
                      (ds_q == '0);
  // A process with nothing to hand back finishes on the accept beat.
  assign proc_early = frame_oob || (cnt_q[frame_i] == '0) || (used_q == '0);

  assign fill_inc  = fill_q + CNT_W'(1);
  assign fill_last = (32'(fill_inc) == 32'(cap_lat_q));
  assign used_dec  = used_q - CNT_W'(1);
  assign pidx_inc  = pidx_q + CNT_W'(1);
  // The walk stops at the end of the list or once no slot is left in use; any
  // remaining entries of the list are dropped.
  assign proc_last = (pidx_inc == cnt_q[frame_q]) || (used_q == CNT_W'(1));

  assign div_bad    = (div_rsp.rem != '0) || (div_rsp.quot >= OFF_W'(cap_lat_q));
  assign defer_full = 32'(cnt_q[frame_q]) >= MAX_SLOTS;

  // Read data of the stack is registered in the RAM, so the multiply sits alone.
  assign mul = (SLOT_W+DSZ_W)'(stk_rdata) * (SLOT_W+DSZ_W)'(ds_q);

  // ---------------------------------------------------------------------------
  // Next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (mode)
            MODE_INIT:    if (!cap_big && (cap_cfg_q != '0)) state_d = S_FILL;
            MODE_ALLOC:   if (!alloc_full) state_d = S_ALLOC;
            MODE_FREE:    if (!free_early) state_d = S_DIV;
            MODE_PROCESS: if (!proc_early) state_d = S_PROC_RD;
            default:      ;
          endcase
        end
      end
      S_FILL:    if (fill_last) state_d = S_IDLE;
      S_ALLOC:   state_d = S_IDLE;
      S_DIV:     if (div_rsp.done) state_d = S_IDLE;
      S_PROC_RD: state_d = S_PROC_WR;
      S_PROC_WR: state_d = proc_last ? S_IDLE : S_PROC_RD;
      default:   state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath updates, RAM controls and the result beat.
  // ---------------------------------------------------------------------------
  logic                resp;
  logic [STATUS_W-1:0] resp_status;
  logic [SLOT_W-1:0]   resp_idx;
  logic [OFF_W-1:0]    resp_off;

  always_comb begin
    used_d    = used_q;
    cap_lat_d = cap_lat_q;
    ready_d   = ready_q;
    vis_d     = vis_q;
    cnt_d     = cnt_q;
    fill_d    = fill_q;
    pidx_d    = pidx_q;

    resp        = 1'b0;
    resp_status = ST_OK;
    resp_idx    = '0;
    resp_off    = '0;

    stk_we    = 1'b0;
    stk_waddr = fill_q[SLOT_W-1:0];
    stk_wdata = fill_q[SLOT_W-1:0];
    stk_re    = 1'b0;
    stk_raddr = used_q[SLOT_W-1:0];

    dfr_we    = 1'b0;
    dfr_waddr = {frame_q, cnt_q[frame_q][SLOT_W-1:0]};
    dfr_wdata = div_rsp.quot[SLOT_W-1:0];
    dfr_re    = 1'b0;
    dfr_raddr = {frame_q, pidx_q[SLOT_W-1:0]};

    div_req.start    = 1'b0;
    div_req.dividend = handle_offset_i;
    div_req.divisor  = ds_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (mode)
            MODE_INIT: begin
              if (cap_big) begin
                resp        = 1'b1;
                resp_status = ST_BIG;
              end else begin
                cap_lat_d = cap_cfg_q;
                ready_d   = 1'b1;
                vis_d     = vreq_q && (htype_q < HEAP_RTV);
                used_d    = '0;
                fill_d    = '0;
                for (int f = 0; f < FRAMES; f++) begin
                  cnt_d[f] = '0;
                end
                // A zero-size heap has nothing to fill.
                resp = (cap_cfg_q == '0);
              end
            end
            MODE_ALLOC: begin
              if (alloc_full) begin
                resp        = 1'b1;
                resp_status = ST_FULL;
              end else begin
                stk_re = 1'b1;
              end
            end
            MODE_FREE: begin
              if (!handle_valid_i || frame_oob) begin
                resp        = 1'b1;
                resp_status = ST_IGNORED;
              end else if (ready_q && (used_q == '0)) begin
                resp        = 1'b1;
                resp_status = ST_EMPTY;
              end else if (ds_q == '0) begin
                resp        = 1'b1;
                resp_status = ST_BAD;
              end else begin
                div_req.start = 1'b1;
              end
            end
            MODE_PROCESS: begin
              if (frame_oob) begin
                resp        = 1'b1;
                resp_status = ST_IGNORED;
              end else if (proc_early) begin
                cnt_d[frame_i] = '0;
                resp           = 1'b1;
              end else begin
                pidx_d = '0;
              end
            end
            default: ;
          endcase
        end
      end

      S_FILL: begin
        // Identity fill of the stack, one entry per cycle.
        stk_we = 1'b1;
        fill_d = fill_inc;
        resp   = fill_last;
      end

      S_ALLOC: begin
        resp     = 1'b1;
        resp_idx = stk_rdata;
        resp_off = mul[OFF_W-1:0];
        used_d   = used_q + CNT_W'(1);
      end

      S_DIV: begin
        if (div_rsp.done) begin
          resp = 1'b1;
          if (div_bad) begin
            resp_status = ST_BAD;
          end else if (defer_full) begin
            resp_status = ST_FULL;
          end else begin
            dfr_we         = 1'b1;
            cnt_d[frame_q] = cnt_q[frame_q] + CNT_W'(1);
            resp_idx       = div_rsp.quot[SLOT_W-1:0];
          end
        end
      end

      S_PROC_RD: begin
        dfr_re = 1'b1;
      end

      S_PROC_WR: begin
        // Push the deferred index back on top of the stack.
        stk_we    = 1'b1;
        stk_waddr = used_dec[SLOT_W-1:0];
        stk_wdata = dfr_rdata;
        used_d    = used_dec;
        pidx_d    = pidx_inc;
        if (proc_last) begin
          cnt_d[frame_q] = '0;
          resp           = 1'b1;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      used_q    <= '0;
      cap_lat_q <= '0;
      ready_q   <= 1'b0;
      vis_q     <= 1'b0;
      fill_q    <= '0;
      pidx_q    <= '0;
      done_o    <= 1'b0;
      for (int f = 0; f < FRAMES; f++) begin
        cnt_q[f] <= '0;
      end
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      cap_lat_q <= cap_lat_d;
      ready_q   <= ready_d;
      vis_q     <= vis_d;
      fill_q    <= fill_d;
      pidx_q    <= pidx_d;
      done_o    <= resp;
      cnt_q     <= cnt_d;
    end
  end

  // The result beat carries the flags and the used count as they stand after the item.
  always_ff @(posedge clk_i) begin
    if (resp) begin
      status_o      <= resp_status;
      slot_index_o  <= resp_idx;
      slot_offset_o <= resp_off;
      gpu_valid_o   <= vis_d;
      in_use_o      <= used_d;
    end
  end

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the deferred-free slot allocator: directed corner cases,
// a full-stack and full-list stress phase, then random settings phases, all scoreboarded.
// Depends on dfsa_pkg and the deferred_free_slot_allocator RTL.
`timescale 1ns / 100ps

module testbench;
  import dfsa_pkg::*;

  // Heap types that the package does not name.
  localparam logic [HTYPE_W-1:0] HEAP_VIEWS = 2'd0;
  localparam logic [HTYPE_W-1:0] HEAP_DEPTH = 2'd3;

  localparam int RANDOM_ITEMS = 1100;
  localparam int TAIL_CYCLES  = 64;

  // One entry of the stimulus script: a command beat, a register write, or a pause
  // that holds the sender off until every outstanding result has come back.
  typedef enum logic [1:0] {
    OP_CMD,
    OP_REG_WRITE,
    OP_DRAIN
  } op_kind_e;

  typedef struct {
    op_kind_e         kind;
    mode_e            mode;
    logic             hvalid;
    logic [OFF_W-1:0] hoff;
    logic [FRAME_W-1:0] frame;
    logic [1:0]       reg_idx;
    logic [31:0]      reg_val;
    int unsigned      gap;
  } alloc_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   index;
    logic [OFF_W-1:0]    offset;
    logic                gpu;
    logic [CNT_W-1:0]    in_use;
  } slot_result_t;

  typedef enum logic [2:0] {
    DRV_FETCH,
    DRV_GAP,
    DRV_CMD,
    DRV_DRAIN,
    DRV_APB_ACCESS,
    DRV_APB_WRITE
  } drv_state_e;

  // Clock, reset and every block input start at known values.
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CFG_AW-1:0]   paddr = '0;
  logic [CFG_DW-1:0]   pwdata = '0;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          mode_i = '0;
  logic                handle_valid_i = 1'b0;
  logic [OFF_W-1:0]    handle_offset_i = '0;
  logic [FRAME_W-1:0]  frame_i = '0;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [SLOT_W-1:0]   slot_index_o;
  logic [OFF_W-1:0]    slot_offset_o;
  logic                gpu_valid_o;
  logic [CNT_W-1:0]    in_use_o;

  deferred_free_slot_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .start           (start),
    .busy            (busy),
    .mode_i          (mode_i),
    .handle_valid_i  (handle_valid_i),
    .handle_offset_i (handle_offset_i),
    .frame_i         (frame_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .slot_index_o    (slot_index_o),
    .slot_offset_o   (slot_offset_o),
    .gpu_valid_o     (gpu_valid_o),
    .in_use_o        (in_use_o)
  );

  // Shadow copy of the allocator: registers at their reset values, heap not ready.
  logic [CAP_W-1:0]   sh_capacity = '0;
  logic [DSZ_W-1:0]   sh_dsz = DSZ_RESET;
  logic [HTYPE_W-1:0] sh_heap_type = '0;
  logic               sh_visible_req = 1'b0;
  logic [CAP_W-1:0]   sh_cap_latched = '0;
  logic               sh_ready = 1'b0;
  logic               sh_visible = 1'b0;
  logic [CNT_W-1:0]   sh_used = '0;
  logic [SLOT_W-1:0]  sh_free_stack [MAX_SLOTS];
  logic [SLOT_W-1:0]  sh_deferred [FRAMES][MAX_SLOTS];
  logic [CNT_W-1:0]   sh_defer_cnt [FRAMES] = '{default: '0};

  alloc_op_t    allocator_ops [$];
  slot_result_t pending_slot_results [$];
  alloc_op_t    cur_op;
  slot_result_t oldest_result;
  drv_state_e   drv_state = DRV_FETCH;
  int unsigned  gap_left = 0;
  int unsigned  issued_items = 0;
  int unsigned  results_seen = 0;
  logic         stim_done = 1'b0;
  int unsigned  error_count = 0;
  int unsigned  reg_writes = 0;
  int unsigned  cmd_count [4] = '{default: 0};
  int unsigned  burst_left = 0;
  int unsigned  gen_cap = 0;
  int unsigned  gen_dsz = 32;
  int unsigned  phases = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Reset is held low at the start of the run and never asserted again.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Hard stop in case the block hangs.
  initial begin
    #30_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Predicts one result beat from one accepted command, updating the shadow state.
  function automatic slot_result_t compute_slot_result(mode_e m, logic hvalid,
                                                       logic [OFF_W-1:0] hoff,
                                                       logic [FRAME_W-1:0] frame);
    slot_result_t r;
    int unsigned  i;
    int unsigned  prod;
    int unsigned  quot;
    int unsigned  rem;
    r = '0;
    r.status = ST_OK;
    case (m)
      MODE_INIT: begin
        // Samplers have the lower limit; a rejected init leaves everything alone.
        if (sh_capacity > MAX_SLOTS ||
            (sh_heap_type == HEAP_SAMPLER && sh_capacity > SAMPLER_LIMIT)) begin
          r.status = ST_BIG;
        end else begin
          sh_cap_latched = sh_capacity;
          sh_ready = 1'b1;
          sh_visible = sh_visible_req && (sh_heap_type < HEAP_RTV);
          for (i = 0; i < sh_cap_latched; i++) sh_free_stack[i] = SLOT_W'(i);
          sh_used = '0;
          for (i = 0; i < FRAMES; i++) sh_defer_cnt[i] = '0;
        end
      end
      MODE_ALLOC: begin
        if (!sh_ready || sh_used >= sh_cap_latched) begin
          r.status = ST_FULL;
        end else begin
          r.index = sh_free_stack[sh_used];
          sh_used = sh_used + 1'b1;
          prod = r.index * sh_dsz;
          r.offset = prod[OFF_W-1:0];
        end
      end
      MODE_FREE: begin
        if (!hvalid || int'(frame) >= FRAMES) begin
          r.status = ST_IGNORED;
        end else if (sh_ready && sh_used == 0) begin
          r.status = ST_EMPTY;
        end else if (sh_dsz == 0) begin
          r.status = ST_BAD;
        end else begin
          quot = hoff / sh_dsz;
          rem  = hoff % sh_dsz;
          if (rem != 0 || quot >= sh_cap_latched) begin
            r.status = ST_BAD;
          end else if (sh_defer_cnt[frame] >= MAX_SLOTS) begin
            r.status = ST_FULL;
          end else begin
            r.index = quot[SLOT_W-1:0];
            sh_deferred[frame][sh_defer_cnt[frame]] = quot[SLOT_W-1:0];
            sh_defer_cnt[frame] = sh_defer_cnt[frame] + 1'b1;
          end
        end
      end
      default: begin
        if (int'(frame) >= FRAMES) begin
          r.status = ST_IGNORED;
        end else begin
          // Entries beyond the number of slots in use are dropped.
          for (i = 0; i < sh_defer_cnt[frame]; i++) begin
            if (sh_used > 0) begin
              sh_used = sh_used - 1'b1;
              sh_free_stack[sh_used] = sh_deferred[frame][i];
            end
          end
          sh_defer_cnt[frame] = '0;
        end
      end
    endcase
    r.gpu = sh_visible;
    r.in_use = sh_used;
    return r;
  endfunction

  task automatic apply_reg_write(logic [1:0] idx, logic [31:0] val);
    case (idx)
      REG_CAPACITY: sh_capacity = val[CAP_W-1:0];
      REG_DSZ:      sh_dsz = val[DSZ_W-1:0];
      REG_HTYPE:    sh_heap_type = val[HTYPE_W-1:0];
      default:      sh_visible_req = val[0];
    endcase
  endtask

  // The sender works in bursts: a burst opens with a random gap, then runs back to back.
  function automatic int unsigned next_gap();
    int unsigned g;
    g = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(48, 1);
      g = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(30, 1);
    end
    burst_left--;
    return g;
  endfunction

  task automatic queue_cmd(mode_e m, logic hv, logic [OFF_W-1:0] hoff,
                           logic [FRAME_W-1:0] frame);
    alloc_op_t op;
    op = '{kind: OP_CMD, mode: m, hvalid: hv, hoff: hoff, frame: frame,
           reg_idx: '0, reg_val: '0, gap: next_gap()};
    allocator_ops.push_back(op);
  endtask

  task automatic queue_reg(logic [1:0] idx, int unsigned val);
    alloc_op_t op;
    op = '{kind: OP_REG_WRITE, mode: MODE_INIT, hvalid: 1'b0, hoff: '0, frame: '0,
           reg_idx: idx, reg_val: val, gap: 0};
    allocator_ops.push_back(op);
    if (idx == REG_CAPACITY) gen_cap = val;
    if (idx == REG_DSZ) gen_dsz = val;
  endtask

  task automatic queue_drain();
    alloc_op_t op;
    op = '{kind: OP_DRAIN, mode: MODE_INIT, hvalid: 1'b0, hoff: '0, frame: '0,
           reg_idx: '0, reg_val: '0, gap: 0};
    allocator_ops.push_back(op);
  endtask

  // Puts the current command on the ports and raises start.
  task automatic present_cmd();
    start           <= 1'b1;
    mode_i          <= cur_op.mode;
    handle_valid_i  <= cur_op.hvalid;
    handle_offset_i <= cur_op.hoff;
    frame_i         <= cur_op.frame;
    drv_state       <= DRV_CMD;
  endtask

  // Takes the next script entry. start is assigned exactly once here, so a command
  // that follows back to back keeps start high without a glitch.
  task automatic launch_next_op();
    if (allocator_ops.size() == 0) begin
      start     <= 1'b0;
      drv_state <= DRV_FETCH;
    end else begin
      cur_op = allocator_ops.pop_front();
      if (cur_op.kind != OP_CMD) begin
        start     <= 1'b0;
        drv_state <= DRV_DRAIN;
      end else if (cur_op.gap != 0) begin
        start     <= 1'b0;
        gap_left  <= cur_op.gap;
        drv_state <= DRV_GAP;
      end else begin
        present_cmd();
      end
    end
  endtask

  // Driver. A command beat is taken at an edge where start is high and busy is low;
  // the expected result is computed right there. Register writes and pauses wait
  // until every result issued so far has been seen and the block is idle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      case (drv_state)
        DRV_FETCH: begin
          if (allocator_ops.size() != 0) begin
            launch_next_op();
          end else if (issued_items == results_seen && !busy) begin
            stim_done <= 1'b1;
          end
        end
        DRV_GAP: begin
          if (gap_left <= 1) begin
            present_cmd();
          end else begin
            gap_left <= gap_left - 1;
          end
        end
        DRV_CMD: begin
          if (!busy) begin
            pending_slot_results.push_back(compute_slot_result(cur_op.mode, cur_op.hvalid,
                                                               cur_op.hoff, cur_op.frame));
            issued_items <= issued_items + 1;
            cmd_count[cur_op.mode]++;
            launch_next_op();
          end
        end
        DRV_DRAIN: begin
          if (issued_items == results_seen && !busy) begin
            if (cur_op.kind == OP_REG_WRITE) begin
              // Setup phase of the write.
              psel      <= 1'b1;
              penable   <= 1'b0;
              pwrite    <= 1'b1;
              paddr     <= {cur_op.reg_idx, 2'b00};
              pwdata    <= cur_op.reg_val;
              drv_state <= DRV_APB_ACCESS;
            end else begin
              drv_state <= DRV_FETCH;
            end
          end
        end
        DRV_APB_ACCESS: begin
          penable   <= 1'b1;
          drv_state <= DRV_APB_WRITE;
        end
        default: begin
          // The register takes the value at this edge if the slave is ready.
          if (pready) begin
            apply_reg_write(cur_op.reg_idx, cur_op.reg_val);
            reg_writes++;
            psel      <= 1'b0;
            penable   <= 1'b0;
            pwrite    <= 1'b0;
            drv_state <= DRV_FETCH;
          end
        end
      endcase
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Monitor. Every result beat lasts one cycle and is compared with the oldest
  // outstanding prediction, field by field.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_slot_results.size() == 0) begin
        $display("%0t: result beat with nothing outstanding, status %0d index %0d",
                 $time, status_o, slot_index_o);
        error_count++;
      end else begin
        oldest_result = pending_slot_results.pop_front();
        check_field("status", oldest_result.status, status_o);
        check_field("slot_index", oldest_result.index, slot_index_o);
        check_field("slot_offset", oldest_result.offset, slot_offset_o);
        check_field("gpu_valid", oldest_result.gpu, gpu_valid_o);
        check_field("in_use", oldest_result.in_use, in_use_o);
        results_seen <= results_seen + 1;
      end
    end
  end

  // Builds the whole script up front, then waits for the run to settle and reports.
  initial begin
    int unsigned r;
    int unsigned k;
    int unsigned span;
    int unsigned slot;
    int unsigned hoff32;
    int unsigned phase_len;
    int unsigned random_items;
    int unsigned i;

    // Directed part, starting from the reset settings: capacity 0, stride 32.
    queue_cmd(MODE_ALLOC, 1'b0, '0, 2'd0);          // allocate before init is full
    queue_cmd(MODE_FREE, 1'b1, '0, 2'd0);           // no latched capacity: bad handle
    queue_cmd(MODE_FREE, 1'b0, 20'hFFFFF, 2'd3);    // empty handle is ignored
    queue_cmd(MODE_PROCESS, 1'b1, 20'hFFFFF, 2'd1); // empty list
    queue_cmd(MODE_INIT, 1'b0, '0, 2'd0);           // zero capacity heap
    queue_cmd(MODE_ALLOC, 1'b1, 20'hFFFFF, 2'd2);
    queue_cmd(MODE_FREE, 1'b1, '0, 2'd0);           // free on an empty heap
    queue_reg(REG_CAPACITY, 8191);
    queue_cmd(MODE_INIT, 1'b0, '0, 2'd0);           // far too large
    queue_reg(REG_CAPACITY, 4097);
    queue_cmd(MODE_INIT, 1'b0, '0, 2'd0);           // one over the slot limit
    queue_reg(REG_HTYPE, HEAP_SAMPLER);
    queue_reg(REG_CAPACITY, 2049);
    queue_cmd(MODE_INIT, 1'b0, '0, 2'd0);           // one over the sampler limit
    queue_reg(REG_CAPACITY, 2048);
    queue_reg(REG_VISIBLE, 1);
    queue_cmd(MODE_INIT, 1'b0, '0, 2'd0);           // visible sampler heap
    queue_reg(REG_HTYPE, HEAP_DEPTH);
    queue_reg(REG_CAPACITY, 4096);
    queue_reg(REG_DSZ, 256);
    queue_cmd(MODE_INIT, 1'b0, '0, 2'd0);           // visibility dropped for depth
    queue_cmd(MODE_ALLOC, 1'b0, '0, 2'd0);
    queue_cmd(MODE_ALLOC, 1'b0, '0, 2'd0);
    queue_cmd(MODE_FREE, 1'b1, 20'(4095 * 256), 2'd0);  // top slot
    queue_cmd(MODE_FREE, 1'b1, 20'd257, 2'd0);          // misaligned
    queue_cmd(MODE_FREE, 1'b1, '0, 2'd3);
    queue_cmd(MODE_PROCESS, 1'b0, '0, 2'd0);
    queue_cmd(MODE_ALLOC, 1'b0, '0, 2'd0);          // gets the top slot back
    queue_reg(REG_HTYPE, HEAP_RTV);
    queue_reg(REG_CAPACITY, 4);
    queue_reg(REG_DSZ, 0);
    queue_cmd(MODE_INIT, 1'b0, '0, 2'd0);
    queue_cmd(MODE_ALLOC, 1'b0, '0, 2'd0);
    queue_cmd(MODE_FREE, 1'b1, '0, 2'd0);           // zero stride is a bad handle
    queue_reg(REG_DSZ, 1);
    queue_cmd(MODE_FREE, 1'b1, 20'd4, 2'd2);        // index equal to the capacity
    queue_cmd(MODE_FREE, 1'b1, 20'd3, 2'd2);
    queue_cmd(MODE_FREE, 1'b1, 20'd2, 2'd2);
    queue_cmd(MODE_FREE, 1'b1, 20'd1, 2'd2);
    queue_cmd(MODE_PROCESS, 1'b0, '0, 2'd2);        // more entries than slots in use
    queue_cmd(MODE_ALLOC, 1'b0, '0, 2'd0);

    // Stress: fill the whole stack, overflow it, then fill one deferred list to the
    // brim and one past it. A stride of 300 also makes offsets wrap at 20 bits.
    queue_reg(REG_HTYPE, HEAP_VIEWS);
    queue_reg(REG_VISIBLE, 0);
    queue_reg(REG_DSZ, 300);
    queue_reg(REG_CAPACITY, 4096);
    queue_cmd(MODE_INIT, 1'b0, '0, 2'd0);
    for (i = 0; i <= MAX_SLOTS; i++) queue_cmd(MODE_ALLOC, $urandom_range(1, 0), $urandom,
                                               $urandom_range(3, 0));
    for (i = 0; i <= MAX_SLOTS; i++) queue_cmd(MODE_FREE, 1'b1,
                                               20'(300 * $urandom_range(3495, 0)), 2'd1);
    queue_cmd(MODE_PROCESS, 1'b0, $urandom, 2'd1);

    // Random part: phases of fresh settings, each opened by an init, followed by a
    // mix that favors allocate and well-formed frees, with some broken handles.
    queue_drain();
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      phases++;
      r = $urandom_range(19, 0);
      if (r < 13)      queue_reg(REG_CAPACITY, $urandom_range(64, 1));
      else if (r == 13) queue_reg(REG_CAPACITY, 0);
      else if (r < 17) queue_reg(REG_CAPACITY, $urandom_range(4095, 65));
      else if (r == 17) queue_reg(REG_CAPACITY, 4096);
      else if (r == 18) queue_reg(REG_CAPACITY, $urandom_range(8191, 4097));
      else             queue_reg(REG_CAPACITY, 2048);
      if ($urandom_range(1, 0) == 1) begin
        r = $urandom_range(19, 0);
        if (r < 12)      queue_reg(REG_DSZ, $urandom_range(64, 1));
        else if (r < 16) queue_reg(REG_DSZ, $urandom_range(256, 65));
        else if (r < 18) queue_reg(REG_DSZ, $urandom_range(511, 257));
        else if (r == 18) queue_reg(REG_DSZ, 0);
        else             queue_reg(REG_DSZ, 256);
      end
      if ($urandom_range(1, 0) == 1) queue_reg(REG_HTYPE, $urandom_range(3, 0));
      if ($urandom_range(1, 0) == 1) queue_reg(REG_VISIBLE, $urandom_range(1, 0));
      queue_cmd(MODE_INIT, $urandom_range(1, 0), $urandom, $urandom_range(3, 0));
      random_items++;
      span = (gen_cap == 0) ? 1 : ((gen_cap > MAX_SLOTS) ? MAX_SLOTS : gen_cap);
      phase_len = $urandom_range(80, 20);
      repeat (phase_len) begin
        r = $urandom_range(99, 0);
        if (r < 42) begin
          queue_cmd(MODE_ALLOC, $urandom_range(1, 0), $urandom, $urandom_range(3, 0));
          random_items++;
        end else if (r < 80) begin
          slot = $urandom_range(span - 1, 0);
          k = $urandom_range(9, 0);
          if (k < 6)       hoff32 = gen_dsz * slot;
          else if (k == 6) hoff32 = $urandom;
          else if (k == 7) hoff32 = gen_dsz * slot + $urandom_range((gen_dsz > 1) ?
                                                                    gen_dsz - 1 : 1, 1);
          else             hoff32 = gen_dsz * (span + $urandom_range(3, 0));
          queue_cmd(MODE_FREE, 1'b1, hoff32[OFF_W-1:0], $urandom_range(3, 0));
          random_items++;
        end else if (r < 92) begin
          queue_cmd(MODE_PROCESS, $urandom_range(1, 0), $urandom, $urandom_range(3, 0));
          random_items++;
        end else if (r < 95) begin
          queue_cmd(MODE_INIT, $urandom_range(1, 0), $urandom, $urandom_range(3, 0));
          random_items++;
        end else if (r < 97) begin
          queue_drain();
        end else begin
          // Empty handle: the block only reports it as ignored.
          queue_cmd(MODE_FREE, 1'b0, $urandom, $urandom_range(3, 0));
        end
      end
    end

    wait (stim_done);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_slot_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_slot_results.size());
      error_count += pending_slot_results.size();
    end
    $display("Checked %0d results: %0d init, %0d allocate, %0d free, %0d process beats.",
             results_seen, cmd_count[MODE_INIT], cmd_count[MODE_ALLOC],
             cmd_count[MODE_FREE], cmd_count[MODE_PROCESS]);
    $display("Full stack and full deferred list stress, %0d random phases, %0d register writes.",
             phases, reg_writes);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
